@@ hw/rtl/bpsm_pkg.sv @@
// Shared types and constants for the buffer pool slot manager.
`timescale 1ns / 1ps
package bpsm_pkg;

	localparam int unsigned SIZE_W = 24;
	localparam int unsigned ADDR_W = 32;
	localparam int unsigned PCT_W  = 7;
	localparam int unsigned CNT_W  = 32;

	localparam logic [31:0] PCT_BASE = 32'd100;

	localparam logic [PCT_W-1:0]  PCT_RESET = 7'd20;
	localparam logic [SIZE_W-1:0] THR_RESET = 24'd1024;

	// configuration register indexes
	localparam logic REG_OVERSIZE_PCT = 1'b0;
	localparam logic REG_LARGE_THR    = 1'b1;

	// request action codes
	localparam logic ACT_ACQUIRE = 1'b0;
	localparam logic ACT_RELEASE = 1'b1;

	// result status codes
	localparam logic [2:0] STS_EXACT         = 3'd0;
	localparam logic [2:0] STS_OVERSIZE      = 3'd1;
	localparam logic [2:0] STS_MISS_POOLED   = 3'd2;
	localparam logic [2:0] STS_MISS_UNPOOLED = 3'd3;
	localparam logic [2:0] STS_ALLOC_FAILED  = 3'd4;
	localparam logic [2:0] STS_RELEASED      = 3'd5;
	localparam logic [2:0] STS_FREE_EXT      = 3'd6;
	localparam logic [2:0] STS_NULL          = 3'd7;

	typedef struct packed {
		logic              action;
		logic [SIZE_W-1:0] request_size;
		logic [ADDR_W-1:0] buffer_address;
	} req_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [ADDR_W-1:0] granted_address;
		logic [SIZE_W-1:0] granted_size;
		logic              in_pool;
		logic [CNT_W-1:0]  hit_count;
		logic [CNT_W-1:0]  miss_count;
		logic [CNT_W-1:0]  saturation_count;
		logic [CNT_W-1:0]  large_alloc_count;
		logic [CNT_W-1:0]  small_alloc_count;
		logic [3:0]        pool_entries;
	} rsp_t;

	// control broadcast from the sequencer to every cell
	typedef struct packed {
		logic cmp_en;     // register match flags
		logic take_exact; // mark the first exact match busy
		logic take_over;  // mark the first oversize match busy
		logic release_en; // free the first address match
		logic append;     // write a new slot at index == count
	} cell_ctl_t;

	// priority chain passed cell to cell
	typedef struct packed {
		logic              ex_hit;
		logic [ADDR_W-1:0] ex_addr;
		logic              ov_hit;
		logic [ADDR_W-1:0] ov_addr;
		logic [SIZE_W-1:0] ov_size;
		logic              rl_hit;
	} chain_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_PICK
	} state_t;

endpackage

@@ hw/rtl/buffer_pool_slot_manager_core.sv @@
// Top level of the buffer pool slot manager: sequencer, counters and cell row.
`timescale 1ns / 1ps
// Buffer pool slot manager. Keeps up to POOL_SLOTS buffer slots (address,
// size, busy) in a row of cells. An acquire beat takes the lowest free slot
// of exactly the requested size, else the lowest free slot with
// req <= size and size*100 <= req*(100+oversize_percent); on a miss the
// external address carried in the beat is pooled while there is room, else
// handed back unpooled (address 0 means the external allocation failed).
// A release beat frees the lowest slot holding the address. Every request
// beat yields exactly one response beat carrying the wrapping counters.
// Steps: the accept in S_IDLE registers the request and the oversize limit
// (one 24x8 multiply), S_CMP registers every cell's match flags, and S_PICK
// walks the priority chain through the cells and commits the result into the
// response register. req_ready is low between accept and commit, so a new
// request is taken only once the last one is committed; a response waiting in
// the output register holds the commit, and with it the request side, until
// that response is taken.
// Slot contents are not cleared after reset; the fill count marks which
// cells hold entries, so no clearing pass is needed.
module buffer_pool_slot_manager_core #(
	parameter int unsigned POOL_SLOTS = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_ready,
	input  bpsm_pkg::req_t                    req_data,
	output logic                              rsp_valid,
	input  logic                              rsp_ready,
	output bpsm_pkg::rsp_t                    rsp_data,
	input  logic                              cfg_we,
	input  logic                              cfg_idx,
	input  logic [bpsm_pkg::SIZE_W-1:0]       cfg_wdata
);

	localparam int unsigned CW = $clog2(POOL_SLOTS + 1);

	bpsm_pkg::state_t            state_q, state_d;
	bpsm_pkg::req_t              item_q;
	logic [31:0]                 limit_q;
	logic [bpsm_pkg::PCT_W-1:0]  pct_q;
	logic [bpsm_pkg::SIZE_W-1:0] thr_q;
	logic [CW-1:0]               count_q;
	logic [31:0]                 count_ext;
	logic [31:0]                 hits_q, misses_q, sats_q, large_q, small_q;
	bpsm_pkg::rsp_t              rsp_q, rsp_d;
	logic                        rsp_valid_q;

	bpsm_pkg::cell_ctl_t         ctl;
	bpsm_pkg::chain_t            chain [POOL_SLOTS+1];
	bpsm_pkg::chain_t            ce;

	logic                        accept, room, commit;
	logic                        take_ex, take_ov, do_rel, do_app;
	logic                        inc_hit, inc_miss, inc_sat, inc_large, inc_small;

	assign accept = req_valid && req_ready;
	assign room   = !rsp_valid_q || rsp_ready;
	assign ce     = chain[POOL_SLOTS];

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pct_q <= bpsm_pkg::PCT_RESET;
			thr_q <= bpsm_pkg::THR_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				bpsm_pkg::REG_OVERSIZE_PCT: pct_q <= cfg_wdata[bpsm_pkg::PCT_W-1:0];
				bpsm_pkg::REG_LARGE_THR:    thr_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// ---------------- sequencer ----------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bpsm_pkg::S_IDLE: if (req_valid) state_d = bpsm_pkg::S_CMP;
			bpsm_pkg::S_CMP:  state_d = bpsm_pkg::S_PICK;
			bpsm_pkg::S_PICK: if (room) state_d = bpsm_pkg::S_IDLE;
			default:          state_d = bpsm_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		commit    = 1'b0;
		unique case (state_q)
			bpsm_pkg::S_IDLE: req_ready = 1'b1;
			bpsm_pkg::S_CMP:  ;
			bpsm_pkg::S_PICK: commit = room;
			default:          ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bpsm_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// request capture; limit = req * (100 + pct) fits 32 bits
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q  <= req_data;
			limit_q <= 32'(req_data.request_size) * (bpsm_pkg::PCT_BASE + 32'(pct_q));
		end
	end

	// ---------------- decision on the chain end ----------------
	always_comb begin
		take_ex   = 1'b0;
		take_ov   = 1'b0;
		do_rel    = 1'b0;
		do_app    = 1'b0;
		inc_hit   = 1'b0;
		inc_miss  = 1'b0;
		inc_sat   = 1'b0;
		inc_large = 1'b0;
		inc_small = 1'b0;
		rsp_d     = '0;
		if (item_q.action == bpsm_pkg::ACT_ACQUIRE) begin
			if (ce.ex_hit) begin
				take_ex               = 1'b1;
				inc_hit               = 1'b1;
				rsp_d.status          = bpsm_pkg::STS_EXACT;
				rsp_d.granted_address = ce.ex_addr;
				rsp_d.granted_size    = item_q.request_size;
				rsp_d.in_pool         = 1'b1;
			end else if (ce.ov_hit) begin
				take_ov               = 1'b1;
				inc_hit               = 1'b1;
				rsp_d.status          = bpsm_pkg::STS_OVERSIZE;
				rsp_d.granted_address = ce.ov_addr;
				rsp_d.granted_size    = ce.ov_size;
				rsp_d.in_pool         = 1'b1;
			end else begin
				inc_miss = 1'b1;
				if (item_q.buffer_address == '0) begin
					rsp_d.status = bpsm_pkg::STS_ALLOC_FAILED;
				end else begin
					inc_large             = item_q.request_size > thr_q;
					inc_small             = !(item_q.request_size > thr_q);
					rsp_d.granted_address = item_q.buffer_address;
					rsp_d.granted_size    = item_q.request_size;
					if (count_q < CW'(POOL_SLOTS)) begin
						do_app        = 1'b1;
						rsp_d.status  = bpsm_pkg::STS_MISS_POOLED;
						rsp_d.in_pool = 1'b1;
					end else begin
						inc_sat      = 1'b1;
						rsp_d.status = bpsm_pkg::STS_MISS_UNPOOLED;
					end
				end
			end
		end else begin
			if (item_q.buffer_address == '0) begin
				rsp_d.status = bpsm_pkg::STS_NULL;
			end else if (ce.rl_hit) begin
				do_rel       = 1'b1;
				rsp_d.status = bpsm_pkg::STS_RELEASED;
			end else begin
				rsp_d.status = bpsm_pkg::STS_FREE_EXT;
			end
		end
		// counters as they stand after this beat
		rsp_d.hit_count         = hits_q + 32'(inc_hit);
		rsp_d.miss_count        = misses_q + 32'(inc_miss);
		rsp_d.saturation_count  = sats_q + 32'(inc_sat);
		rsp_d.large_alloc_count = large_q + 32'(inc_large);
		rsp_d.small_alloc_count = small_q + 32'(inc_small);
		count_ext               = 32'(count_q) + 32'(do_app);
		rsp_d.pool_entries      = count_ext[3:0];
	end

	always_comb begin
		ctl.cmp_en     = state_q == bpsm_pkg::S_CMP;
		ctl.take_exact = commit && take_ex;
		ctl.take_over  = commit && take_ov;
		ctl.release_en = commit && do_rel;
		ctl.append     = commit && do_app;
	end

	// ---------------- counters and response register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			hits_q      <= '0;
			misses_q    <= '0;
			sats_q      <= '0;
			large_q     <= '0;
			small_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				count_q     <= count_q + CW'(do_app);
				hits_q      <= rsp_d.hit_count;
				misses_q    <= rsp_d.miss_count;
				sats_q      <= rsp_d.saturation_count;
				large_q     <= rsp_d.large_alloc_count;
				small_q     <= rsp_d.small_alloc_count;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	// ---------------- cell row ----------------
	assign chain[0] = '0;

	for (genvar i = 0; i < POOL_SLOTS; i++) begin : g_cell
		bpsm_cell #(
			.IDX   (i),
			.CNT_W (CW)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.count     (count_q),
			.req_size  (item_q.request_size),
			.req_addr  (item_q.buffer_address),
			.limit     (limit_q),
			.chain_in  (chain[i]),
			.chain_out (chain[i+1])
		);
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(POOL_SLOTS))
		else $error("slot count beyond pool size");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> (count_q == $past(count_q) + CW'(1)))
		else $error("slot count moved by other than one");

	a_accept_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == bpsm_pkg::S_CMP))
		else $error("accepted beat not followed by compare");

	a_rsp_from_pick: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == bpsm_pkg::S_PICK))
		else $error("response raised outside pick");

	a_hit_pooled: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && (rsp_q.status == bpsm_pkg::STS_EXACT
			|| rsp_q.status == bpsm_pkg::STS_OVERSIZE)) |-> rsp_q.in_pool)
		else $error("pool hit not marked as pooled");
`endif

endmodule

@@ hw/rtl/bpsm_cell.sv @@
// One pool slot: stored entry, match flags and a link of the priority chain.
`timescale 1ns / 1ps
module bpsm_cell #(
	parameter int unsigned IDX   = 0,
	parameter int unsigned CNT_W = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  bpsm_pkg::cell_ctl_t                 ctl,
	input  logic [CNT_W-1:0]                    count,
	input  logic [bpsm_pkg::SIZE_W-1:0]         req_size,
	input  logic [bpsm_pkg::ADDR_W-1:0]         req_addr,
	input  logic [31:0]                         limit,
	input  bpsm_pkg::chain_t                    chain_in,
	output bpsm_pkg::chain_t                    chain_out
);

	logic [bpsm_pkg::ADDR_W-1:0] addr_q;
	logic [bpsm_pkg::SIZE_W-1:0] size_q;
	logic                        busy_q;
	logic                        ex_q, ov_q, rl_q;
	logic                        live;
	logic                        here;
	logic [31:0]                 size_x100;
	logic                        ex_sel, ov_sel, rl_sel;

	assign live      = CNT_W'(IDX) < count;
	assign here      = CNT_W'(IDX) == count;
	assign size_x100 = 32'(size_q) * bpsm_pkg::PCT_BASE;

	assign ex_sel = ex_q & ~chain_in.ex_hit;
	assign ov_sel = ov_q & ~chain_in.ov_hit;
	assign rl_sel = rl_q & ~chain_in.rl_hit;

	always_comb begin
		chain_out.ex_hit  = chain_in.ex_hit | ex_q;
		chain_out.ex_addr = ex_sel ? addr_q : chain_in.ex_addr;
		chain_out.ov_hit  = chain_in.ov_hit | ov_q;
		chain_out.ov_addr = ov_sel ? addr_q : chain_in.ov_addr;
		chain_out.ov_size = ov_sel ? size_q : chain_in.ov_size;
		chain_out.rl_hit  = chain_in.rl_hit | rl_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ex_q   <= 1'b0;
			ov_q   <= 1'b0;
			rl_q   <= 1'b0;
		end else begin
			if (ctl.cmp_en) begin
				ex_q <= live & ~busy_q & (size_q == req_size);
				ov_q <= live & ~busy_q & (size_q >= req_size) & (size_x100 <= limit);
				rl_q <= live & (addr_q == req_addr);
			end
			if ((ctl.take_exact && ex_sel) || (ctl.take_over && ov_sel)
					|| (ctl.append && here)) begin
				busy_q <= 1'b1;
			end else if (ctl.release_en && rl_sel) begin
				busy_q <= 1'b0;
			end
		end
	end

	// entry payload, meaningful only once appended
	always_ff @(posedge clk) begin
		if (ctl.append && here) begin
			addr_q <= req_addr;
			size_q <= req_size;
		end
	end

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the buffer pool slot manager core.
`timescale 1ns / 1ps
module testbench;
	import bpsm_pkg::*;

	localparam int unsigned POOL_SLOTS  = 8;
	localparam int unsigned QUIET_LIMIT = 2000; // cycles with no beat before giving up
	localparam int unsigned PHASE_ITEMS = 160;

	// Predicts each response beat from its own copy of the slot table and counters,
	// then compares the beats the block returns against those predictions in order.
	class slot_pool_checker;
		logic [ADDR_W-1:0] slot_addr [POOL_SLOTS];
		logic [SIZE_W-1:0] slot_size [POOL_SLOTS];
		logic              slot_busy [POOL_SLOTS];
		int unsigned       fill;
		logic [PCT_W-1:0]  pct;
		logic [SIZE_W-1:0] thr;
		logic [CNT_W-1:0]  hits, misses, saturations, large_allocs, small_allocs;
		rsp_t              expected_grants[$];
		int unsigned       errors;
		int unsigned       checked;
		int unsigned       status_seen[8];

		function new();
			for (int i = 0; i < POOL_SLOTS; i++) begin
				slot_addr[i] = '0;
				slot_size[i] = '0;
				slot_busy[i] = 1'b0;
			end
			fill = 0;
			pct = PCT_RESET;
			thr = THR_RESET;
			hits = '0;
			misses = '0;
			saturations = '0;
			large_allocs = '0;
			small_allocs = '0;
			errors = 0;
			checked = 0;
			for (int i = 0; i < 8; i++) status_seen[i] = 0;
		endfunction

		function void set_register(input logic idx, input logic [SIZE_W-1:0] value);
			if (idx == REG_OVERSIZE_PCT) pct = value[PCT_W-1:0];
			else thr = value;
		endfunction

		function int unsigned pending_count();
			return expected_grants.size();
		endfunction

		function void note_request(input req_t beat);
			rsp_t             want;
			int               pick;
			longint unsigned  ceiling;
			want = '0;
			pick = -1;
			if (beat.action == ACT_ACQUIRE) begin
				for (int i = 0; i < fill; i++)
					if (pick < 0 && !slot_busy[i] && slot_size[i] == beat.request_size) pick = i;
				if (pick >= 0) begin
					slot_busy[pick] = 1'b1;
					hits++;
					want.status = STS_EXACT;
					want.granted_address = slot_addr[pick];
					want.granted_size = beat.request_size;
					want.in_pool = 1'b1;
				end else begin
					ceiling = longint'(beat.request_size) * (longint'(PCT_BASE) + longint'(pct));
					for (int i = 0; i < fill; i++)
						if (pick < 0 && !slot_busy[i] && slot_size[i] >= beat.request_size &&
								longint'(slot_size[i]) * longint'(PCT_BASE) <= ceiling)
							pick = i;
					if (pick >= 0) begin
						slot_busy[pick] = 1'b1;
						hits++;
						want.status = STS_OVERSIZE;
						want.granted_address = slot_addr[pick];
						want.granted_size = slot_size[pick];
						want.in_pool = 1'b1;
					end else begin
						misses++;
						if (beat.buffer_address == '0) begin
							want.status = STS_ALLOC_FAILED;
						end else begin
							if (beat.request_size > thr) large_allocs++;
							else small_allocs++;
							want.granted_address = beat.buffer_address;
							want.granted_size = beat.request_size;
							if (fill < POOL_SLOTS) begin
								slot_addr[fill] = beat.buffer_address;
								slot_size[fill] = beat.request_size;
								slot_busy[fill] = 1'b1;
								fill++;
								want.status = STS_MISS_POOLED;
								want.in_pool = 1'b1;
							end else begin
								saturations++;
								want.status = STS_MISS_UNPOOLED;
							end
						end
					end
				end
			end else if (beat.buffer_address == '0) begin
				want.status = STS_NULL;
			end else begin
				want.status = STS_FREE_EXT;
				for (int i = 0; i < fill; i++)
					if (pick < 0 && slot_addr[i] == beat.buffer_address) pick = i;
				if (pick >= 0) begin
					slot_busy[pick] = 1'b0;
					want.status = STS_RELEASED;
				end
			end
			want.hit_count = hits;
			want.miss_count = misses;
			want.saturation_count = saturations;
			want.large_alloc_count = large_allocs;
			want.small_alloc_count = small_allocs;
			want.pool_entries = fill[3:0];
			expected_grants.insert(expected_grants.size(), want);
		endfunction

		task flag_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
			errors++;
			$display("mismatch at response %0d: %s got 0x%0h want 0x%0h",
				checked, what, got, want);
		endtask

		task check_grant(input rsp_t got);
			rsp_t want;
			checked++;
			if (expected_grants.size() == 0) begin
				flag_mismatch("response with nothing outstanding, status", 32'(got.status),
					32'd0);
			end else begin
				want = expected_grants.pop_front();
				status_seen[want.status]++;
				if (got.status !== want.status)
					flag_mismatch("status", 32'(got.status), 32'(want.status));
				if (got.granted_address !== want.granted_address)
					flag_mismatch("granted_address", got.granted_address, want.granted_address);
				if (got.granted_size !== want.granted_size)
					flag_mismatch("granted_size", 32'(got.granted_size),
						32'(want.granted_size));
				if (got.in_pool !== want.in_pool)
					flag_mismatch("in_pool", 32'(got.in_pool), 32'(want.in_pool));
				if (got.hit_count !== want.hit_count)
					flag_mismatch("hit_count", got.hit_count, want.hit_count);
				if (got.miss_count !== want.miss_count)
					flag_mismatch("miss_count", got.miss_count, want.miss_count);
				if (got.saturation_count !== want.saturation_count)
					flag_mismatch("saturation_count", got.saturation_count, want.saturation_count);
				if (got.large_alloc_count !== want.large_alloc_count)
					flag_mismatch("large_alloc_count", got.large_alloc_count,
						want.large_alloc_count);
				if (got.small_alloc_count !== want.small_alloc_count)
					flag_mismatch("small_alloc_count", got.small_alloc_count,
						want.small_alloc_count);
				if (got.pool_entries !== want.pool_entries)
					flag_mismatch("pool_entries", 32'(got.pool_entries),
						32'(want.pool_entries));
			end
		endtask
	endclass

	logic              clk;
	logic              arst_n;
	logic              req_valid;
	logic              req_ready;
	req_t              req_data;
	logic              rsp_valid;
	logic              rsp_ready;
	rsp_t              rsp_data;
	logic              cfg_we;
	logic              cfg_idx;
	logic [SIZE_W-1:0] cfg_wdata;

	slot_pool_checker sb = new();

	// idle odds per cycle, in percent, for each side; the main sequence changes them per phase
	int unsigned req_gap_pct = 38;
	int unsigned rsp_gap_pct = 38;
	// cycles the response side should refuse beats; picked up by the response process
	int unsigned rsp_hold_req = 0;
	int unsigned settings_run = 1;

	buffer_pool_slot_manager_core #(
		.POOL_SLOTS(POOL_SLOTS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_data(req_data),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp_data(rsp_data),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Offer one request beat, possibly after a few idle cycles, and hold it until taken.
	// valid is only lowered when a gap is actually inserted, so back-to-back beats
	// keep it high without a same-step drop.
	task automatic send_request(input req_t beat);
		bit lowered;
		lowered = 1'b0;
		while ($urandom_range(99) < req_gap_pct) begin
			if (!lowered) begin
				req_valid <= 1'b0;
				lowered = 1'b1;
			end
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_data <= beat;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		sb.note_request(beat);
	endtask

	task automatic acquire_buf(input logic [SIZE_W-1:0] size, input logic [ADDR_W-1:0] addr);
		req_t beat;
		beat.action = ACT_ACQUIRE;
		beat.request_size = size;
		beat.buffer_address = addr;
		send_request(beat);
	endtask

	// request_size is don't-care on a release, so it gets random content
	task automatic give_back(input logic [ADDR_W-1:0] addr);
		req_t beat;
		beat.action = ACT_RELEASE;
		beat.request_size = 24'($urandom());
		beat.buffer_address = addr;
		send_request(beat);
	endtask

	// Wait until every accepted request has been answered; the block is then idle.
	task automatic drain();
		while (sb.pending_count() != 0) @(posedge clk);
	endtask

	// Both registers in consecutive cycles; cfg_we stays high across them.
	task automatic set_registers(input logic [SIZE_W-1:0] pct_word,
			input logic [SIZE_W-1:0] thr);
		cfg_we <= 1'b1;
		cfg_idx <= REG_OVERSIZE_PCT;
		cfg_wdata <= pct_word;
		@(posedge clk);
		sb.set_register(REG_OVERSIZE_PCT, pct_word);
		cfg_idx <= REG_LARGE_THR;
		cfg_wdata <= thr;
		@(posedge clk);
		sb.set_register(REG_LARGE_THR, thr);
		cfg_we <= 1'b0;
	endtask

	// Random request, mostly aimed at what the predicted table holds right now:
	// exact sizes of existing slots, sizes just inside or outside the oversize
	// window, and releases of pooled addresses. The rest is noise.
	function automatic req_t random_request();
		req_t        beat;
		int unsigned roll, kind, k, s, lo, span;
		beat.action = ACT_ACQUIRE;
		beat.request_size = 24'($urandom());
		beat.buffer_address = $urandom();
		roll = $urandom_range(99);
		kind = $urandom_range(99);
		k = (sb.fill > 0) ? $urandom_range(sb.fill - 1) : 0;
		if (roll < 55) begin
			if ($urandom_range(9) == 0) beat.buffer_address = '0; // failed external alloc
			if (sb.fill > 0 && kind < 35) begin
				beat.request_size = sb.slot_size[k];
			end else if (sb.fill > 0 && kind < 60) begin
				// smallest request that still fits this slot, minus a little slack
				s = 32'(sb.slot_size[k]);
				span = PCT_BASE + 32'(sb.pct);
				lo = (s * PCT_BASE + span - 1) / span;
				lo = (lo > 2) ? lo - 2 : 0;
				beat.request_size = 24'($urandom_range(s, lo));
			end else if (kind < 80) begin
				beat.request_size = 24'($urandom_range(2047)); // around the reset threshold
			end
		end else begin
			beat.action = ACT_RELEASE;
			if (sb.fill > 0 && kind < 60) beat.buffer_address = sb.slot_addr[k];
			else if (kind >= 85) beat.buffer_address = '0;
		end
		return beat;
	endfunction

	// One register setting: wait for idle, program, then stream random requests.
	task automatic run_phase(input logic [SIZE_W-1:0] pct_word, input logic [SIZE_W-1:0] thr,
			input int unsigned req_gap, input int unsigned rsp_gap, input int unsigned hold);
		drain();
		set_registers(pct_word, thr);
		settings_run++;
		req_gap_pct = req_gap;
		rsp_gap_pct = rsp_gap;
		rsp_hold_req = hold;
		for (int i = 0; i < PHASE_ITEMS; i++) send_request(random_request());
		req_valid <= 1'b0;
	endtask

	// Response side: checks every accepted beat, stalls at random, and honors
	// a requested hold-off by counting it down here.
	initial begin : response_side
		int unsigned hold;
		hold = 0;
		rsp_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_valid && rsp_ready) sb.check_grant(rsp_data);
			if (rsp_hold_req != 0) begin
				hold = rsp_hold_req;
				rsp_hold_req = 0;
			end
			if (hold != 0) begin
				rsp_ready <= 1'b0;
				hold--;
			end else begin
				rsp_ready <= ($urandom_range(99) >= rsp_gap_pct);
			end
		end
	end

	// Ends the run if neither channel nor the register port moves for too long.
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || cfg_we) quiet = 0;
			else quiet++;
		end
		$display("TB_ERROR");
		$finish;
	end

	initial begin : main_sequence
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req_data <= '0;
		cfg_we <= 1'b0;
		cfg_idx <= REG_OVERSIZE_PCT;
		cfg_wdata <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at reset settings (20 percent, threshold 1024).
		acquire_buf(24'd100, '0);                    // empty table, external alloc failed
		give_back('0);                               // null release is ignored
		give_back(32'h0000_1234);                    // unknown address: free externally
		acquire_buf(24'd0, 32'hFFFF_FFFF);           // zero size gets pooled
		acquire_buf(24'd100, 32'h0000_1000);
		acquire_buf(24'd120, 32'h0000_2000);         // 120 does not fit the busy 100 slot
		acquire_buf(24'd1025, 32'h8000_0001);        // just above threshold: large
		acquire_buf(24'hFF_FFFF, 32'h5555_AAAA);     // largest size
		acquire_buf(24'd1024, 32'hAAAA_5555);        // at threshold: small
		give_back(32'h0000_1000);
		give_back(32'h0000_1000);                    // slot already free, stays free
		acquire_buf(24'd90, 32'h0000_3000);          // oversize hit on the 100 slot
		give_back(32'h0000_1000);
		give_back(32'h0000_2000);
		acquire_buf(24'd100, 32'h0000_4000);         // exact hit wins
		acquire_buf(24'd100, 32'h0000_5000);         // 120 slot right at the window edge
		give_back(32'hFFFF_FFFF);
		acquire_buf(24'd0, 32'h0000_6000);           // free zero-size slot is an exact hit
		acquire_buf(24'd7, 32'h8000_0001);           // duplicate address in the table
		acquire_buf(24'd5, 32'h0000_0004);           // table now full
		acquire_buf(24'd2000, 32'h0ABC_DEF0);        // full: handed out unpooled
		acquire_buf(24'd3, '0);                      // failed alloc with full table
		give_back(32'h8000_0001);                    // frees the lower of the duplicates
		give_back(32'h0ABC_DEF0);                    // unpooled buffer: free externally
		req_valid <= 1'b0;

		// Random part over several settings, extremes first.
		run_phase(24'd0, 24'd0, 38, 38, 0);
		run_phase(24'd127, 24'hFF_FFFF, 38, 38, 0);
		// no idling on either side, and a long receiver hold-off to back up the block
		run_phase(24'd100, 24'd1024, 0, 0, 150);
		run_phase(24'(($urandom() & 32'h00FF_FF80) | $urandom_range(127)), 24'($urandom()),
			38, 38, 0);
		run_phase(24'd20, 24'd1024, 38, 38, 60);

		drain();
		repeat (10) @(posedge clk); // any stray response shows up here
		$display("covered %0d responses over %0d register settings, table held %0d slots",
			sb.checked, settings_run, sb.fill);
		$display("exact %0d oversize %0d pooled %0d unpooled %0d failed %0d released %0d ext %0d null %0d",
			sb.status_seen[STS_EXACT], sb.status_seen[STS_OVERSIZE],
			sb.status_seen[STS_MISS_POOLED], sb.status_seen[STS_MISS_UNPOOLED],
			sb.status_seen[STS_ALLOC_FAILED], sb.status_seen[STS_RELEASED],
			sb.status_seen[STS_FREE_EXT], sb.status_seen[STS_NULL]);
		if (sb.errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
